// ===== src/pfr_pkg.sv =====
// Package: shared constants and types for the Pareto front ranker.
package pfr_pkg;
  localparam int PopMax   = 64;
  localparam int NumObj   = 4;
  localparam int ObjWidth = 16;
  localparam int FieldObj = 4;
  localparam int IdxW     = 6;
  localparam int CntW     = 7;
  localparam int Lanes    = 4;
  localparam int ObjCap   = (NumObj < FieldObj) ? NumObj : FieldObj;
  localparam int SxW      = (ObjWidth < 16) ? ObjWidth : 16;

  typedef logic signed [15:0] obj_t;
  typedef obj_t [FieldObj-1:0] objv_t;
  typedef logic [PopMax-1:0] row_t;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_CMP   = 6'b000010,
    ST_CWAIT = 6'b000100,
    ST_PEEL  = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_EWAIT = 6'b100000
  } state_t;

  // Per-lane comparison outcome handed to the merge stage.
  typedef struct packed {
    logic [Lanes-1:0] beats;
    logic [Lanes-1:0] beaten;
  } lane_res_t;

  function automatic obj_t sx(input logic [15:0] raw);
    logic [SxW-1:0] v;
    begin
      v = raw[SxW-1:0];
      sx = obj_t'($signed(v));
    end
  endfunction
endpackage

// ===== src/pfr_lane.sv =====
// One comparison lane: dominance both ways between a pivot and a partner.
module pfr_lane (
  input  pfr_pkg::objv_t  a,
  input  pfr_pkg::objv_t  b,
  input  logic [2:0]      m,
  output logic            a_beats_b,
  output logic            b_beats_a
);
  always_comb begin
    a_beats_b = 1'b1;
    b_beats_a = 1'b1;
    for (int e = 0; e < pfr_pkg::FieldObj; e++) begin
      if (3'(e) < m) begin
        if (!(a[e] < b[e])) a_beats_b = 1'b0;
        if (!(b[e] < a[e])) b_beats_a = 1'b0;
      end
    end
  end
endmodule

// ===== src/pfr_merge.sv =====
// Merge stage: folds lane results into the dominance rows.
module pfr_merge (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        en,
  input  logic [pfr_pkg::IdxW-1:0]    piv,
  input  logic [pfr_pkg::IdxW-1:0]    base,
  input  logic [pfr_pkg::Lanes-1:0]   lane_ok,
  input  pfr_pkg::lane_res_t          res,
  output pfr_pkg::row_t               dom_row [pfr_pkg::PopMax]
);
  pfr_pkg::row_t dom_r   [pfr_pkg::PopMax];
  pfr_pkg::row_t dom_nxt [pfr_pkg::PopMax];

  // each lane sets one bit in the pivot's row or one in the partner's row
  always_comb begin
    logic [pfr_pkg::IdxW-1:0] q;
    for (int p = 0; p < pfr_pkg::PopMax; p++) dom_nxt[p] = dom_r[p];
    q = '0;
    if (en) begin
      for (int l = 0; l < pfr_pkg::Lanes; l++) begin
        q = base + pfr_pkg::IdxW'(l);
        if (lane_ok[l] && res.beats[l])  dom_nxt[piv][q] = 1'b1;
        if (lane_ok[l] && res.beaten[l]) dom_nxt[q][piv] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < pfr_pkg::PopMax; p++)
      dom_r[p] <= clr ? '0 : dom_nxt[p];
  end

  assign dom_row = dom_r;
endmodule

// ===== src/pareto_front_ranker.sv =====
// Top level: Pareto front ranker with a four-lane dominance comparator.
// Words are loaded one per accepted input word. Each loaded individual is
// compared with up to four earlier ones per cycle by four parallel lanes,
// both directions at once; the store is split into four banks so each lane
// reads its own bank. Each item passes through the accepting load state,
// the lane passes and a wait state while the merge stage folds in the last
// lane results. On a word marked last, front peeling strips the fronts one
// after another and hands over; then one result word per stored individual
// leaves in load order through an output register, one per cycle when not
// stalled. No new input word is taken from the last word until the final
// result leaves. Items beyond 64 are dropped and flagged on every result of
// the run.
module pareto_front_ranker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_objective_0,
  input  logic signed [15:0]  in_objective_1,
  input  logic signed [15:0]  in_objective_2,
  input  logic signed [15:0]  in_objective_3,
  input  logic                in_last_individual,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          out_individual_index,
  output logic [5:0]          out_front_rank,
  output logic                out_population_truncated,
  output logic                out_last_result
);
  localparam int P = pfr_pkg::PopMax;
  localparam int L = pfr_pkg::Lanes;
  localparam int IW = pfr_pkg::IdxW;
  localparam int CW = pfr_pkg::CntW;
  localparam int LW = $clog2(L);
  localparam int D = P / L;

  pfr_pkg::state_t st_r, st_nxt;
  logic [2:0] cfg_r;
  logic [CW-1:0] n_r;
  logic ovf_r, last_r;
  logic [IW-1:0] piv_r, base_r, emit_r, rank_r;
  // bank b holds individuals b, b+4, b+8, ...
  pfr_pkg::objv_t store [L][D];
  pfr_pkg::objv_t piv_obj_r;
  pfr_pkg::row_t rem_r, front, blocked;
  // rank per individual; shifts down one place per emitted word
  logic [IW-1:0] rank_st_r [P];

  // objectives in use, clamped
  logic [2:0] m;
  always_comb begin
    m = cfg_r;
    if (m == 3'd0) m = 3'd1;
    if (m > 3'(pfr_pkg::ObjCap)) m = 3'(pfr_pkg::ObjCap);
  end

  logic acc_in;
  assign in_stall = (st_r != pfr_pkg::ST_LOAD);
  assign acc_in   = in_valid && !in_stall;

  // lane stage: partner reads, registered comparison results
  pfr_pkg::lane_res_t res_c, res_r;
  logic [L-1:0] ok_c, ok_r;
  logic         vld_r;
  logic [IW-1:0] bq_r;
  for (genvar l = 0; l < L; l++) begin : g_lane
    assign ok_c[l] = (CW'(base_r) + CW'(l)) < CW'(piv_r);
    pfr_lane u_lane (
      .a(piv_obj_r), .b(store[l][base_r[IW-1:LW]]), .m(m),
      .a_beats_b(res_c.beats[l]), .b_beats_a(res_c.beaten[l])
    );
  end

  pfr_pkg::row_t dom_row [P];

  // an individual still in play is blocked while any remaining one beats it
  always_comb begin
    blocked = '0;
    for (int p = 0; p < P; p++) if (rem_r[p]) blocked = blocked | dom_row[p];
  end

  always_comb begin
    front = rem_r & ~blocked;
    if (front == '0) front = rem_r;
  end

  logic clr;
  assign clr = acc_in && n_r == '0;

  pfr_merge u_merge (
    .clk(clk), .clr(clr), .en(vld_r), .piv(piv_r), .base(bq_r), .lane_ok(ok_r),
    .res(res_r), .dom_row(dom_row)
  );

  logic cmp_done;
  assign cmp_done = (CW'(base_r) + CW'(L)) >= CW'(piv_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pfr_pkg::ST_LOAD:  if (acc_in) st_nxt = pfr_pkg::ST_CMP;
      pfr_pkg::ST_CMP:   if (cmp_done) st_nxt = pfr_pkg::ST_CWAIT;
      pfr_pkg::ST_CWAIT: st_nxt = last_r ? pfr_pkg::ST_PEEL : pfr_pkg::ST_LOAD;
      pfr_pkg::ST_PEEL:  if (rem_r == '0) st_nxt = pfr_pkg::ST_EMIT;
      pfr_pkg::ST_EMIT:  if (!out_valid || !out_stall) st_nxt = pfr_pkg::ST_EWAIT;
      pfr_pkg::ST_EWAIT: if (!out_valid || !out_stall)
                           st_nxt = (CW'(emit_r) >= n_r) ? pfr_pkg::ST_LOAD
                                                          : pfr_pkg::ST_EWAIT;
      default:           st_nxt = pfr_pkg::ST_LOAD;
    endcase
  end

  logic stored;
  assign stored = acc_in && n_r < CW'(P);

  // next result word goes into the output register
  logic emit_go;
  assign emit_go = (st_r == pfr_pkg::ST_EMIT || st_r == pfr_pkg::ST_EWAIT) &&
                   (!out_valid || !out_stall) && CW'(emit_r) < n_r &&
                   !(st_r == pfr_pkg::ST_EWAIT && emit_r == '0);

  always_ff @(posedge clk) begin
    if (stored) begin
      store[n_r[LW-1:0]][n_r[IW-1:LW]] <= '{pfr_pkg::sx(in_objective_3),
                                             pfr_pkg::sx(in_objective_2),
                                             pfr_pkg::sx(in_objective_1),
                                             pfr_pkg::sx(in_objective_0)};
      piv_obj_r <= '{pfr_pkg::sx(in_objective_3), pfr_pkg::sx(in_objective_2),
                     pfr_pkg::sx(in_objective_1), pfr_pkg::sx(in_objective_0)};
    end
    res_r <= res_c;
    ok_r  <= ok_c & {L{st_r == pfr_pkg::ST_CMP}};
    bq_r  <= base_r;
    for (int p = 0; p < P - 1; p++) begin
      if (st_r == pfr_pkg::ST_PEEL && front[p]) rank_st_r[p] <= rank_r;
      else if (emit_go) rank_st_r[p] <= rank_st_r[p + 1];
    end
    if (st_r == pfr_pkg::ST_PEEL && front[P-1]) rank_st_r[P-1] <= rank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pfr_pkg::ST_LOAD;
      cfg_r <= 3'd4;
      n_r <= '0;
      ovf_r <= 1'b0;
      last_r <= 1'b0;
      piv_r <= '0;
      base_r <= '0;
      emit_r <= '0;
      rank_r <= '0;
      rem_r <= '0;
      vld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      vld_r <= (st_r == pfr_pkg::ST_CMP);
      if (cfg_we) cfg_r <= cfg_wdata;
      if (acc_in) begin
        last_r <= in_last_individual;
        base_r <= '0;
        if (stored) begin
          piv_r <= n_r[IW-1:0];
          n_r <= n_r + 1'b1;
        end else begin
          piv_r <= '0;
          ovf_r <= 1'b1;
        end
      end
      if (st_r == pfr_pkg::ST_CMP) base_r <= base_r + IW'(L);
      if (st_r == pfr_pkg::ST_CWAIT && last_r) begin
        rank_r <= '0;
        for (int p = 0; p < P; p++) rem_r[p] <= (CW'(p) < n_r);
      end
      if (st_r == pfr_pkg::ST_PEEL && rem_r != '0) begin
        rem_r <= rem_r & ~front;
        if (rank_r != '1) rank_r <= rank_r + 1'b1;
      end
      if (st_r == pfr_pkg::ST_PEEL && rem_r == '0) emit_r <= '0;
      if (emit_go) begin
        out_valid <= 1'b1;
        out_individual_index <= emit_r;
        out_front_rank <= rank_st_r[0];
        out_population_truncated <= ovf_r;
        out_last_result <= (CW'(emit_r) + 1'b1 == n_r);
        emit_r <= emit_r + 1'b1;
        if (CW'(emit_r) + 1'b1 == n_r) begin
          n_r <= '0;
          ovf_r <= 1'b0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during result output");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(P)) else $error("fill count beyond capacity");
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_result) |=> n_r == '0)
    else $error("run not closed after final result");
`endif
endmodule

// ===== tb/tb_pareto_front_ranker.sv =====
// Testbench for the Pareto front ranker: directed table, overflow, full, random runs.
`timescale 1ns / 100ps

module tb_pareto_front_ranker;

  localparam int CycleLimit = 2000000;

  // One directed row: a loaded individual, plus an optional typed-in rank check.
  typedef struct {
    logic signed [15:0] o0, o1, o2, o3;
    logic               last;
    logic [2:0]         obj_sel;   // register value applied before this row's population
    logic               hand_rank; // 1: the rank below is known at a glance
    logic [5:0]         rank;
  } dir_row_t;

  typedef struct {
    logic [5:0] idx;
    logic [5:0] rank;
    logic       trunc;
    logic       last;
  } rank_word_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_wdata;
  logic in_valid, in_stall;
  logic signed [15:0] in_objective_0, in_objective_1, in_objective_2, in_objective_3;
  logic in_last_individual;
  logic out_valid, out_stall;
  logic [5:0] out_individual_index, out_front_rank;
  logic out_population_truncated, out_last_result;

  pareto_front_ranker dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_objective_0(in_objective_0), .in_objective_1(in_objective_1),
    .in_objective_2(in_objective_2), .in_objective_3(in_objective_3),
    .in_last_individual(in_last_individual),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_individual_index(out_individual_index), .out_front_rank(out_front_rank),
    .out_population_truncated(out_population_truncated),
    .out_last_result(out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Predictor state: a copy of the population store and the register.
  logic signed [15:0] pop_obj [pfr_pkg::PopMax][pfr_pkg::FieldObj];
  int unsigned        pop_count;
  logic               pop_dropped;
  logic [2:0]         obj_reg;

  rank_word_t  rank_queue[$];  // ranks still owed by the block
  logic [5:0]  hand_rank_q[$]; // typed-in ranks, aligned with rank_queue
  logic        hand_valid_q[$];
  int          fail_count;
  longint      cycle_count;
  logic        quiet;          // no idling on either side while set

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int unsigned objs_compared();
    int unsigned m;
    m = obj_reg;
    if (m < 1) m = 1;
    if (m > pfr_pkg::ObjCap) m = pfr_pkg::ObjCap;
    return m;
  endfunction

  function automatic logic strictly_better(input int p, input int q, input int unsigned m);
    for (int e = 0; e < m; e++)
      if (pop_obj[p][e] >= pop_obj[q][e]) return 1'b0;
    return 1'b1;
  endfunction

  // Non-dominated sort of the stored population; queues one word per individual.
  task automatic rank_population();
    logic [pfr_pkg::PopMax-1:0] beats_row [pfr_pkg::PopMax];
    int               beaten_by [pfr_pkg::PopMax];
    logic [5:0]       front_of [pfr_pkg::PopMax];
    logic [pfr_pkg::PopMax-1:0] left, front;
    int unsigned m, n, r;
    rank_word_t w;
    m = objs_compared();
    n = pop_count;
    left = '0;
    r = 0;
    for (int p = 0; p < n; p++) begin
      beats_row[p] = '0;
      beaten_by[p] = 0;
    end
    for (int p = 0; p < n; p++) begin
      for (int q = 0; q < n; q++)
        if (strictly_better(p, q, m)) begin
          beats_row[p][q] = 1'b1;
          beaten_by[q]++;
        end
      left[p] = 1'b1;
    end
    while (left != '0) begin
      front = '0;
      for (int p = 0; p < n; p++)
        if (left[p] && beaten_by[p] == 0) front[p] = 1'b1;
      if (front == '0) front = left;
      for (int p = 0; p < n; p++)
        if (front[p]) begin
          front_of[p] = (r > 63) ? 6'd63 : r[5:0];
          for (int q = 0; q < n; q++)
            if (beats_row[p][q] && beaten_by[q] > 0) beaten_by[q]--;
        end
      left &= ~front;
      r++;
    end
    for (int k = 0; k < n; k++) begin
      w.idx = k[5:0];
      w.rank = front_of[k];
      w.trunc = pop_dropped;
      w.last = (k + 1 == n);
      rank_queue = {rank_queue, w};
    end
    pop_count = 0;
    pop_dropped = 1'b0;
  endtask

  // Called once per accepted input word.
  task automatic load_individual(input logic signed [15:0] a, b, c, d, input logic fin);
    if (pop_count < pfr_pkg::PopMax) begin
      pop_obj[pop_count][0] = a;
      pop_obj[pop_count][1] = b;
      pop_obj[pop_count][2] = c;
      pop_obj[pop_count][3] = d;
      pop_count++;
    end else begin
      pop_dropped = 1'b1;
    end
    if (fin) rank_population();
  endtask

  // Present one word and hold it until accepted; random gaps before it.
  // Valid stays high after acceptance until the next gap or idle point.
  task automatic send_word(input logic signed [15:0] a, b, c, d, input logic fin);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_objective_0 <= a;
    in_objective_1 <= b;
    in_objective_2 <= c;
    in_objective_3 <= d;
    in_last_individual <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_individual(a, b, c, d, fin);
  endtask

  // Idle point for a register write: all ranks back, then a settle gap.
  task automatic write_objs(input logic [2:0] v);
    in_valid <= 1'b0;
    while (rank_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    obj_reg = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd_obj(input int style);
    case (style)
      0: return 16'($urandom_range(7) - 4);     // narrow: many ties and dominations
      1: return 16'($urandom_range(255) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  // Output side: random stall, compare each accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rank_queue.size() == 0) begin
          report_mismatch("unexpected rank word, index", out_individual_index, -1);
        end else begin
          rank_word_t w;
          logic hv;
          logic [5:0] hr;
          w = rank_queue.pop_front();
          hv = hand_valid_q.size() ? hand_valid_q.pop_front() : 1'b0;
          hr = hand_rank_q.size() ? hand_rank_q.pop_front() : 6'd0;
          if (out_individual_index !== w.idx)
            report_mismatch("individual_index", out_individual_index, w.idx);
          if (out_front_rank !== w.rank)
            report_mismatch("front_rank", out_front_rank, w.rank);
          if (hv && out_front_rank !== hr)
            report_mismatch("front_rank (table)", out_front_rank, hr);
          if (out_population_truncated !== w.trunc)
            report_mismatch("population_truncated", out_population_truncated, w.trunc);
          if (out_last_result !== w.last)
            report_mismatch("last_result", out_last_result, w.last);
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 19);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("pareto_front_ranker: mismatch");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  task automatic add_row(input logic signed [15:0] a, b, c, d, input logic fin,
                         input logic [2:0] sel, input logic hv, input logic [5:0] r);
    dir_row_t t;
    t.o0 = a; t.o1 = b; t.o2 = c; t.o3 = d;
    t.last = fin; t.obj_sel = sel; t.hand_rank = hv; t.rank = r;
    dir_rows = {dir_rows, t};
  endtask

  initial begin
    int n_items;
    int size, style;
    logic signed [15:0] a, b, c, d;
    fail_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    pop_count = 0;
    pop_dropped = 1'b0;
    obj_reg = 3'd4;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_objective_0 = '0;
    in_objective_1 = '0;
    in_objective_2 = '0;
    in_objective_3 = '0;
    in_last_individual = 1'b0;

    // Directed table. Populations end at last=1; obj_sel of a population's
    // first row is written beforehand.
    // Single individual straight after reset: rank 0.
    add_row(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 3'd4, 1'b1, 6'd0);
    // Extremes: min beats max in all four objectives.
    add_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 3'd4, 1'b1, 6'd1);
    add_row(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b1, 3'd4, 1'b1, 6'd0);
    // Equal in one objective: no domination either way.
    add_row(16'sh0001, 16'sh0001, 16'sh0001, 16'sh0005, 1'b0, 3'd4, 1'b1, 6'd0);
    add_row(16'sh0002, 16'sh0002, 16'sh0002, 16'sh0005, 1'b1, 3'd4, 1'b1, 6'd0);
    // Only objective 0 compared: a chain of three fronts.
    add_row(16'sh0003, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 3'd1, 1'b1, 6'd2);
    add_row(16'sh0002, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 3'd1, 1'b1, 6'd1);
    add_row(16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 3'd1, 1'b1, 6'd0);
    // Register zero counts as one objective.
    add_row(16'sh0010, -16'sh0010, 16'sh0000, 16'sh0000, 1'b0, 3'd0, 1'b1, 6'd0);
    add_row(16'sh0020, -16'sh0020, 16'sh0000, 16'sh0000, 1'b1, 3'd0, 1'b1, 6'd1);
    // Register above four saturates: objective 3 tie blocks domination.
    add_row(16'sh0001, 16'sh0001, 16'sh0001, 16'sh0009, 1'b0, 3'd7, 1'b1, 6'd0);
    add_row(16'sh0002, 16'sh0002, 16'sh0002, 16'sh0009, 1'b1, 3'd7, 1'b1, 6'd0);
    // Two and three objectives, bits toggled in each field.
    add_row(16'sh5555, 16'shaaaa, 16'sh1234, 16'sh4321, 1'b0, 3'd2, 1'b0, 6'd0);
    add_row(16'shaaaa, 16'sh5555, 16'shedcb, 16'shbcde, 1'b1, 3'd2, 1'b0, 6'd0);
    add_row(16'sh0f0f, 16'shf0f0, 16'sh00ff, 16'shff00, 1'b0, 3'd3, 1'b0, 6'd0);
    add_row(16'sh0e0e, 16'shf0ef, 16'sh00fe, 16'shffff, 1'b1, 3'd3, 1'b0, 6'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (i == 0 || dir_rows[i-1].last) write_objs(dir_rows[i].obj_sel);
      send_word(dir_rows[i].o0, dir_rows[i].o1, dir_rows[i].o2, dir_rows[i].o3,
                dir_rows[i].last);
      hand_valid_q = {hand_valid_q, dir_rows[i].hand_rank};
      hand_rank_q = {hand_rank_q, dir_rows[i].rank};
    end
    // Typed-in ranks are given in load order, matching the results.
    write_objs(3'd4);
    hand_valid_q.delete();
    hand_rank_q.delete();

    // Overflow: 66 individuals, two dropped, the last of them ends the run.
    for (int k = 0; k < 66; k++)
      send_word(rnd_obj(1), rnd_obj(1), rnd_obj(1), rnd_obj(1), k == 65);
    // Full population with no overflow, wide values.
    for (int k = 0; k < 64; k++)
      send_word(rnd_obj(2), rnd_obj(2), rnd_obj(2), rnd_obj(2), k == 63);

    // Random populations, mostly small, under changing register settings.
    n_items = 0;
    while (n_items < 234) begin
      write_objs(3'($urandom_range(7)));
      quiet = (n_items > 80 && n_items < 140);
      size = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 10);
      style = $urandom_range(2);
      for (int k = 0; k < size; k++) begin
        a = rnd_obj(style); b = rnd_obj(style); c = rnd_obj(style); d = rnd_obj(style);
        send_word(a, b, c, d, k == size - 1);
      end
      n_items += size;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (rank_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && rank_queue.size() == 0) begin
      $display("pareto_front_ranker: match");
    end else begin
      $display("pareto_front_ranker: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pfr_pkg.sv
src/pfr_lane.sv
src/pfr_merge.sv
src/pareto_front_ranker.sv
tb/tb_pareto_front_ranker.sv
